>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the LEA-128 encryption block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion with an active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication checked on the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lea_pkg.sv
// Types, constants and rotate helpers for the LEA-128 encryption block.
`default_nettype none

package lea_pkg;

    typedef logic [31:0] word_t;

    // Key register indexes on the configuration port
    typedef enum logic [1:0] {
        KEY_WORD0 = 2'd0,
        KEY_WORD1 = 2'd1,
        KEY_WORD2 = 2'd2,
        KEY_WORD3 = 2'd3
    } key_idx_t;

    // Fixed delta constants, restarted for every block
    localparam word_t DELTA0 = 32'hc3efe9db;
    localparam word_t DELTA1 = 32'h88c4d604;
    localparam word_t DELTA2 = 32'he789f229;
    localparam word_t DELTA3 = 32'hc6f98763;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Rotate left by a constant amount in 1..31
    function automatic word_t rotl32(input word_t v, input int unsigned n);
        rotl32 = (v << n) | (v >> (32 - n));
    endfunction

endpackage

`default_nettype wire

>>> sv/lea128_block_encrypt.sv
// LEA-128 block encryption core, one round per cycle on a shared round unit.
//
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    s_tdata: plaintext words 0..3
// m_       out        m_tvalid / m_tready    m_tdata: ciphertext words 0..3
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data: key words 0..3
//
// An item is accepted while the sequencer is idle and then runs ROUND_COUNT rounds
// in the round unit; no new item is accepted until its last round is done.
// The round counter steps the single datapath once per cycle, bar a held last round.
// A finished item waits in the output register; the next item may be accepted
// meanwhile, and the last round holds only while that register is still full.
// Reset clears the key words to zero, the sequencer and the output valid.
`default_nettype none

module lea128_block_encrypt
    import lea_pkg::*;
#(
    parameter int ROUND_COUNT = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata fields from bit 0: plain_word0, plain_word1, plain_word2, plain_word3
    input  wire logic [127:0] s_tdata,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata fields from bit 0: cipher_word0, cipher_word1, cipher_word2, cipher_word3
    output logic [127:0]      m_tdata
);

    localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUND_COUNT - 1);

    state_t         state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t          key_reg [4];
    word_t          t_reg [4];
    word_t          t_next [4];
    word_t          x_reg [4];
    word_t          x_next [4];
    word_t          delta_reg [4];
    word_t          delta_next [4];
    logic [127:0]   out_data_reg;
    logic           out_valid_reg, out_valid_next;

    logic           s_accept;
    logic           last_round;
    logic           out_free;
    logic           advance;
    word_t          d;
    word_t          rt [4];
    word_t          rx [4];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign last_round = (cnt_reg == LAST_ROUND);
    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = (state_reg == ST_RUN) && (!last_round || out_free);

    // Shared round unit: key schedule step, then the ARX round
    always_comb begin
        d     = delta_reg[0];
        rt[0] = rotl32(t_reg[0] + d, 1);
        rt[1] = rotl32(t_reg[1] + rotl32(d, 1), 3);
        rt[2] = rotl32(t_reg[2] + rotl32(d, 2), 6);
        rt[3] = rotl32(t_reg[3] + rotl32(d, 3), 11);
        rx[0] = rotl32((x_reg[0] ^ rt[0]) + (x_reg[1] ^ rt[1]), 9);
        rx[1] = rotl32((x_reg[1] ^ rt[2]) + (x_reg[2] ^ rt[1]), 27);
        rx[2] = rotl32((x_reg[2] ^ rt[3]) + (x_reg[3] ^ rt[1]), 29);
        rx[3] = x_reg[0];
    end

    // Sequencer and working-register next values
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        x_next         = x_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next    = ST_RUN;
                    cnt_next      = '0;
                    t_next        = key_reg;
                    x_next[0]     = s_tdata[31:0];
                    x_next[1]     = s_tdata[63:32];
                    x_next[2]     = s_tdata[95:64];
                    x_next[3]     = s_tdata[127:96];
                    delta_next[0] = DELTA0;
                    delta_next[1] = DELTA1;
                    delta_next[2] = DELTA2;
                    delta_next[3] = DELTA3;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    t_next        = rt;
                    x_next        = rx;
                    delta_next[0] = delta_reg[1];
                    delta_next[1] = delta_reg[2];
                    delta_next[2] = delta_reg[3];
                    delta_next[3] = rotl32(delta_reg[0], 4);
                    cnt_next      = cnt_reg + CNT_W'(1);
                    if (last_round) begin
                        state_next     = ST_IDLE;
                        cnt_next       = '0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Control registers and key words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (key_idx_t'(cfg_index))
                    KEY_WORD0: key_reg[0] <= cfg_data;
                    KEY_WORD1: key_reg[1] <= cfg_data;
                    KEY_WORD2: key_reg[2] <= cfg_data;
                    KEY_WORD3: key_reg[3] <= cfg_data;
                    default:   key_reg[0] <= key_reg[0];
                endcase
            end
        end
    end

    // Working key, block, deltas and the output register
    always_ff @(posedge aclk) begin
        t_reg     <= t_next;
        x_reg     <= x_next;
        delta_reg <= delta_next;
        if (advance && last_round) begin
            out_data_reg <= {rx[3], rx[2], rx[1], rx[0]};
        end
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_idle_cnt_zero, aclk, aresetn, (state_reg != ST_IDLE) || (cnt_reg == '0), "round counter not zero while idle")
    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_accept, (state_reg == ST_RUN) && (cnt_reg == '0), "accepted item did not start at round zero")
    `ASSERT_NEXT(a_hold_on_full, aclk, aresetn, (state_reg == ST_RUN) && last_round && out_valid_reg && !m_tready, (state_reg == ST_RUN) && last_round, "last round left while output register full")
    `ASSERT_NEXT(a_finish_valid, aclk, aresetn, advance && last_round, m_tvalid && s_tready, "finished item not presented")

endmodule

`default_nettype wire

>>> verif/lea_cipher_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the LEA-128 ciphertext of every accepted block and compares results.
module lea_cipher_checker
    import lea_pkg::*;
#(
    parameter int ROUND_COUNT = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    // s_tdata fields from bit 0: plain_word0, plain_word1, plain_word2, plain_word3
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    // m_tdata fields from bit 0: cipher_word0, cipher_word1, cipher_word2, cipher_word3
    input  wire logic [127:0] m_tdata,
    output int                mismatch_count,
    output int                pending_count,
    output int                blocks_checked
);

    // element i holds word i, element 0 in the lowest bits
    typedef logic [3:0][31:0] block_words_t;

    word_t        key_copy [4];
    block_words_t pending_cipher [$];
    int           errors  = 0;
    int           checked = 0;

    function automatic word_t rot_left(input word_t v, input int unsigned n);
        if (n % 32 == 0)
            return v;
        return (v << (n % 32)) | (v >> (32 - n % 32));
    endfunction

    function automatic word_t rot_right(input word_t v, input int unsigned n);
        if (n % 32 == 0)
            return v;
        return (v >> (n % 32)) | (v << (32 - n % 32));
    endfunction

    // Run the full key schedule and ARX rounds on one block
    function automatic block_words_t lea_encrypt(input block_words_t plain,
                                                 input word_t key [4]);
        word_t        delta [4];
        word_t        t0, t1, t2, t3;
        word_t        x0, x1, x2, x3;
        word_t        d, first;
        block_words_t cipher;
        delta = '{DELTA0, DELTA1, DELTA2, DELTA3};
        t0 = key[0];
        t1 = key[1];
        t2 = key[2];
        t3 = key[3];
        x0 = plain[0];
        x1 = plain[1];
        x2 = plain[2];
        x3 = plain[3];
        for (int r = 0; r < ROUND_COUNT; r++) begin
            // advance the working key with this round's delta
            d = delta[r % 4];
            delta[r % 4] = rot_left(d, 4);
            t0 = rot_left(t0 + d, 1);
            t1 = rot_left(t1 + rot_left(d, 1), 3);
            t2 = rot_left(t2 + rot_left(d, 2), 6);
            t3 = rot_left(t3 + rot_left(d, 3), 11);
            // mix the block, first word moves to the back
            first = x0;
            x0 = rot_left((x0 ^ t0) + (x1 ^ t1), 9);
            x1 = rot_right((x1 ^ t2) + (x2 ^ t1), 5);
            x2 = rot_right((x2 ^ t3) + (x3 ^ t1), 3);
            x3 = first;
        end
        cipher[0] = x0;
        cipher[1] = x1;
        cipher[2] = x2;
        cipher[3] = x3;
        return cipher;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Predict on each accepted block with the key held before this edge,
    // then track key writes and compare each result item
    always @(posedge aclk) begin : monitor
        block_words_t want;
        block_words_t got;
        if (!aresetn) begin
            foreach (key_copy[i])
                key_copy[i] = '0;
            pending_cipher.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_cipher.push_back(lea_encrypt(s_tdata, key_copy));
            if (cfg_valid && cfg_ready)
                key_copy[cfg_index] = cfg_data;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_cipher.size() == 0) begin
                    report_error($sformatf("result %h with no block pending", got));
                end else begin
                    want = pending_cipher.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[i] !== want[i])
                            report_error($sformatf("block %0d cipher_word%0d got %h expected %h",
                                                   checked, i, got[i], want[i]));
                    end
                    checked++;
                end
            end
        end
        mismatch_count <= errors;
        pending_count  <= pending_cipher.size();
        blocks_checked <= checked;
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the LEA-128 encryption block: stimulus, key phases and verdict.
module tb;
    import lea_pkg::*;

    localparam int ROUND_COUNT  = 24;
    localparam int BLOCK_CYCLES = ROUND_COUNT + 1;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_BLOCKS = 192;

    typedef logic [3:0][31:0] block_words_t;

    localparam word_t EDGE_WORDS [4] = '{32'h0000_0000, 32'hffff_ffff,
                                         32'h8000_0000, 32'h0000_0001};
    localparam key_idx_t KEY_ORDER [4] = '{KEY_WORD0, KEY_WORD1, KEY_WORD2, KEY_WORD3};

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    key_idx_t     cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    int mismatch_count;
    int pending_count;
    int blocks_checked;

    // sender burst bookkeeping, kept across calls
    int burst_left = 0;
    bit stream_up  = 0;
    int key_settings = 0;

    lea128_block_encrypt #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lea_cipher_checker #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .blocks_checked (blocks_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout with %0d blocks still pending", pending_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic block_words_t make_block(input word_t w0, input word_t w1,
                                                input word_t w2, input word_t w3);
        return {w3, w2, w1, w0};
    endfunction

    // Mostly random word, with edge values at a rate of 1 in odds
    function automatic word_t pick_word(input int odds);
        if ($urandom_range(0, odds - 1) == 0)
            return EDGE_WORDS[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    // Offer one item and hold it until accepted; at the end of a burst, usually open a gap
    task automatic send_block(input block_words_t blk);
        int gap;
        if (burst_left == 0)
            burst_left = $urandom_range(1, 32);
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        stream_up = 1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                stream_up = 0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Drop valid and wait until every block has come back
    task automatic drain();
        if (stream_up)
            s_tvalid <= 1'b0;
        stream_up = 0;
        repeat (2) @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all four key words back to back
    task automatic write_key(input block_words_t key);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= KEY_ORDER[i];
            cfg_data  <= key[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic send_corner_blocks();
        send_block(make_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_block(make_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_block(make_block(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_block(make_block(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        send_block(make_block(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000));
    endtask

    // Receiver: switch among stall patterns, each held for a random span
    initial begin : receiver
        int mode;
        int span;
        m_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 39) != 0);
                endcase
            end
        end
    end

    // Stimulus: directed corners under edge keys, then random key phases
    initial begin : stimulus
        block_words_t key;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= KEY_WORD0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset key of all zeros, no write yet
        send_corner_blocks();
        drain();

        write_key(make_block(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_corner_blocks();
        drain();

        write_key(make_block(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_corner_blocks();
        drain();

        // random keys, the last phase back to an explicit all-zero key
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES - 1)
                key = '0;
            else
                key = make_block(pick_word(4), pick_word(4), pick_word(4), pick_word(4));
            write_key(key);
            for (int n = 0; n < PHASE_BLOCKS; n++)
                send_block(make_block(pick_word(8), pick_word(8), pick_word(8), pick_word(8)));
            drain();
        end

        // let any stray result show up
        repeat (4 * BLOCK_CYCLES) @(posedge aclk);
        $display("Encrypted and checked %0d blocks under %0d key settings plus the reset key,",
                 blocks_checked, key_settings);
        $display("with bursty input, stalled output and edge-value keys and blocks.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> lea128_block_encrypt.f
+incdir+sv
sv/lea_pkg.sv
sv/lea128_block_encrypt.sv
verif/lea_cipher_checker.sv
verif/tb.sv
